### sv/delta_inverse_kinematics_core_defines.svh
// assertion macros shared by the delta kinematics rtl
// the asserting module supplies clk and rst_n
`ifndef DELTA_INVERSE_KINEMATICS_CORE_DEFINES_SVH
`define DELTA_INVERSE_KINEMATICS_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define DIK_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dik assertion failed");

// next-cycle implication, checked out of reset
`define DIK_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dik assertion failed");

`endif

### sv/dik_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dik_pkg;

    // field widths
    localparam int POS_W  = 28;
    localparam int ROD_W  = 54;
    localparam int OUT_W  = 30;
    localparam int DIFF_W = POS_W + 1;
    localparam int SQ_W   = 2 * DIFF_W;
    localparam int ROOT_W = ROD_W / 2;
    localparam int REM_W  = ROOT_W + 1;

    // pipeline layout
    localparam int FRONT_STAGES = 3;
    localparam int SQRT_STAGES  = ROOT_W;
    localparam int PIPE_STAGES  = FRONT_STAGES + SQRT_STAGES + 1;

    // configuration port
    localparam int CFG_IDX_W = 4;

    typedef logic signed [POS_W-1:0] pos_t;
    typedef logic [ROD_W-1:0]        rod_t;
    typedef logic [ROOT_W-1:0]       root_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROD_LENGTH_SQUARED = 4'd0,
        CFG_TOWER_ONE_X        = 4'd1,
        CFG_TOWER_ONE_Y        = 4'd2,
        CFG_TOWER_TWO_X        = 4'd3,
        CFG_TOWER_TWO_Y        = 4'd4,
        CFG_TOWER_THREE_X      = 4'd5,
        CFG_TOWER_THREE_Y      = 4'd6,
        CFG_AXIS_OFFSET        = 4'd7
    } cfg_reg_t;

    // per-stage load enables and valid bits
    typedef struct packed {
        logic [PIPE_STAGES-1:0] load;
        logic [PIPE_STAGES-1:0] valid;
    } pipe_ctrl_t;

endpackage

`default_nettype wire

### sv/dik_pipe_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module dik_pipe_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               out_stall,
    output logic                    in_stall,
    output dik_pkg::pipe_ctrl_t     ctrl
);

    logic [dik_pkg::PIPE_STAGES-1:0] valid_reg;
    logic [dik_pkg::PIPE_STAGES-1:0] valid_next;
    logic [dik_pkg::PIPE_STAGES:0]   ready;

    // a stage may load when it is empty or its content moves on
    always_comb
    begin
        ready[dik_pkg::PIPE_STAGES] = !out_stall;
        for (int i = dik_pkg::PIPE_STAGES - 1; i >= 0; i--)
        begin
            ready[i] = !valid_reg[i] || ready[i+1];
        end
    end

    // valid bits follow the data
    always_comb
    begin
        valid_next = valid_reg;
        if (ready[0])
        begin
            valid_next[0] = in_valid;
        end
        for (int i = 1; i < dik_pkg::PIPE_STAGES; i++)
        begin
            if (ready[i])
            begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign ctrl.load  = ready[dik_pkg::PIPE_STAGES-1:0];
    assign ctrl.valid = valid_reg;
    assign in_stall   = !ready[0];

endmodule

`default_nettype wire

### sv/dik_radicand.sv
`timescale 1ns / 1ps
`default_nettype none

module dik_radicand (
    input  wire logic                                     clk,
    input  wire logic [dik_pkg::FRONT_STAGES-1:0]         load,
    input  wire dik_pkg::pos_t                            tower_x,
    input  wire dik_pkg::pos_t                            tower_y,
    input  wire dik_pkg::rod_t                            rod,
    input  wire dik_pkg::pos_t                            target_x,
    input  wire dik_pkg::pos_t                            target_y,
    output dik_pkg::rod_t                                 radicand,
    output logic                                          bad
);

    logic signed [dik_pkg::DIFF_W-1:0] dx;
    logic signed [dik_pkg::DIFF_W-1:0] dy;
    logic [dik_pkg::DIFF_W-1:0]        mag_x_reg;
    logic [dik_pkg::DIFF_W-1:0]        mag_y_reg;
    logic [dik_pkg::SQ_W-1:0]          sq_x_reg;
    logic [dik_pkg::SQ_W-1:0]          sq_y_reg;
    logic [dik_pkg::SQ_W-1:0]          sum;
    logic                              over;
    dik_pkg::rod_t                     radicand_reg;
    logic                              bad_reg;

    // stage one: offsets from the tower and their magnitudes
    assign dx = dik_pkg::DIFF_W'(tower_x) - dik_pkg::DIFF_W'(target_x);
    assign dy = dik_pkg::DIFF_W'(tower_y) - dik_pkg::DIFF_W'(target_y);

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            mag_x_reg <= dx[dik_pkg::DIFF_W-1] ? $unsigned(-dx) : $unsigned(dx);
            mag_y_reg <= dy[dik_pkg::DIFF_W-1] ? $unsigned(-dy) : $unsigned(dy);
        end
    end

    // stage two: squares
    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            sq_x_reg <= mag_x_reg * mag_x_reg;
            sq_y_reg <= mag_y_reg * mag_y_reg;
        end
    end

    // stage three: radicand and reach check
    assign sum  = sq_x_reg + sq_y_reg;
    assign over = sum > dik_pkg::SQ_W'(rod);

    always_ff @(posedge clk)
    begin
        if (load[2])
        begin
            bad_reg      <= over;
            radicand_reg <= over ? '0 : rod - sum[dik_pkg::ROD_W-1:0];
        end
    end

    assign radicand = radicand_reg;
    assign bad      = bad_reg;

endmodule

`default_nettype wire

### sv/dik_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none

// floor square root, one result bit per stage
module dik_sqrt (
    input  wire logic                                 clk,
    input  wire logic [dik_pkg::SQRT_STAGES-1:0]      load,
    input  wire dik_pkg::rod_t                        radicand,
    output dik_pkg::root_t                            root
);

    localparam int N = dik_pkg::SQRT_STAGES;

    dik_pkg::rod_t                 rad_reg  [0:N-2];
    logic [dik_pkg::REM_W-1:0]     rem_reg  [0:N-2];
    dik_pkg::root_t                root_reg [0:N-1];

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        dik_pkg::rod_t             rad_in;
        logic [dik_pkg::REM_W-1:0] rem_in;
        dik_pkg::root_t            root_in;
        logic [dik_pkg::REM_W+1:0] cur;
        logic [dik_pkg::REM_W+1:0] trial;
        logic                      fits;

        if (k == 0)
        begin : g_first
            assign rad_in  = radicand;
            assign rem_in  = '0;
            assign root_in = '0;
        end
        else
        begin : g_rest
            assign rad_in  = rad_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        // bring down the next bit pair and try root*4+1
        assign cur   = {rem_in, rad_in[dik_pkg::ROD_W-1 -: 2]};
        assign trial = {1'b0, root_in, 2'b01};
        assign fits  = cur >= trial;

        always_ff @(posedge clk)
        begin
            if (load[k])
            begin
                root_reg[k] <= {root_in[dik_pkg::ROOT_W-2:0], fits};
            end
        end

        if (k < N - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (load[k])
                begin
                    rem_reg[k] <= fits ? dik_pkg::REM_W'(cur - trial)
                                       : cur[dik_pkg::REM_W-1:0];
                    rad_reg[k] <= {rad_in[dik_pkg::ROD_W-3:0], 2'b00};
                end
            end
        end
    end

    assign root = root_reg[N-1];

endmodule

`default_nettype wire

### sv/delta_inverse_kinematics_core.sv
// channel    | valid          | stall          | payload
// -----------+----------------+----------------+-----------------------------------------
// target     | target_valid   | target_stall   | target_x, target_y, target_z
// carriage   | carriage_valid | carriage_stall | carriage_one/two/three, unreachable
// cfg        | cfg_write      | (none)         | cfg_index, cfg_data
//
// one transaction per cycle while carriage_stall is low; pipeline: three radicand stages,
// one stage per root bit of the 27-bit square root, and the output register.
// reset clears valid bits and configuration registers only; no clearing pass.
// each stage loads when empty or when its content moves on, so bubbles close up
// under a stall and target_stall rises only when every stage holds a transaction.
`timescale 1ns / 1ps
`default_nettype none

`include "delta_inverse_kinematics_core_defines.svh"

module delta_inverse_kinematics_core (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // target channel
    input  wire logic                                  target_valid,
    output logic                                       target_stall,
    input  wire logic signed [dik_pkg::POS_W-1:0]      target_x,
    input  wire logic signed [dik_pkg::POS_W-1:0]      target_y,
    input  wire logic signed [dik_pkg::POS_W-1:0]      target_z,
    // carriage channel
    output logic                                       carriage_valid,
    input  wire logic                                  carriage_stall,
    output logic signed [dik_pkg::OUT_W-1:0]           carriage_one,
    output logic signed [dik_pkg::OUT_W-1:0]           carriage_two,
    output logic signed [dik_pkg::OUT_W-1:0]           carriage_three,
    output logic                                       unreachable,
    // configuration
    input  wire logic                                  cfg_write,
    input  wire logic [dik_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [dik_pkg::ROD_W-1:0]             cfg_data
);

    localparam int FS = dik_pkg::FRONT_STAGES;
    localparam int SS = dik_pkg::SQRT_STAGES;
    localparam int PS = dik_pkg::PIPE_STAGES;

    dik_pkg::rod_t   rod_length_squared_reg;
    dik_pkg::pos_t   tower_one_x_reg;
    dik_pkg::pos_t   tower_one_y_reg;
    dik_pkg::pos_t   tower_two_x_reg;
    dik_pkg::pos_t   tower_two_y_reg;
    dik_pkg::pos_t   tower_three_x_reg;
    dik_pkg::pos_t   tower_three_y_reg;
    dik_pkg::pos_t   axis_offset_reg;

    dik_pkg::pipe_ctrl_t ctrl;

    dik_pkg::rod_t   rad_one;
    dik_pkg::rod_t   rad_two;
    dik_pkg::rod_t   rad_three;
    logic            bad_one;
    logic            bad_two;
    logic            bad_three;
    dik_pkg::root_t  root_one;
    dik_pkg::root_t  root_two;
    dik_pkg::root_t  root_three;

    dik_pkg::pos_t   tz_reg  [0:PS-2];
    logic            bad_reg [0:SS-1];

    logic signed [dik_pkg::OUT_W-1:0] base;
    logic signed [dik_pkg::OUT_W-1:0] h_one;
    logic signed [dik_pkg::OUT_W-1:0] h_two;
    logic signed [dik_pkg::OUT_W-1:0] h_three;

    logic signed [dik_pkg::OUT_W-1:0] carriage_one_reg;
    logic signed [dik_pkg::OUT_W-1:0] carriage_two_reg;
    logic signed [dik_pkg::OUT_W-1:0] carriage_three_reg;
    logic                             unreachable_reg;

    // configuration registers, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rod_length_squared_reg <= '0;
            tower_one_x_reg        <= '0;
            tower_one_y_reg        <= '0;
            tower_two_x_reg        <= '0;
            tower_two_y_reg        <= '0;
            tower_three_x_reg      <= '0;
            tower_three_y_reg      <= '0;
            axis_offset_reg        <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                dik_pkg::CFG_ROD_LENGTH_SQUARED: rod_length_squared_reg <= cfg_data;
                dik_pkg::CFG_TOWER_ONE_X:   tower_one_x_reg   <= cfg_data[dik_pkg::POS_W-1:0];
                dik_pkg::CFG_TOWER_ONE_Y:   tower_one_y_reg   <= cfg_data[dik_pkg::POS_W-1:0];
                dik_pkg::CFG_TOWER_TWO_X:   tower_two_x_reg   <= cfg_data[dik_pkg::POS_W-1:0];
                dik_pkg::CFG_TOWER_TWO_Y:   tower_two_y_reg   <= cfg_data[dik_pkg::POS_W-1:0];
                dik_pkg::CFG_TOWER_THREE_X: tower_three_x_reg <= cfg_data[dik_pkg::POS_W-1:0];
                dik_pkg::CFG_TOWER_THREE_Y: tower_three_y_reg <= cfg_data[dik_pkg::POS_W-1:0];
                dik_pkg::CFG_AXIS_OFFSET:   axis_offset_reg   <= cfg_data[dik_pkg::POS_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline flow control
    dik_pipe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (target_valid),
        .out_stall (carriage_stall),
        .in_stall  (target_stall),
        .ctrl      (ctrl)
    );

    // radicand per tower
    dik_radicand u_rad_one (
        .clk      (clk),
        .load     (ctrl.load[FS-1:0]),
        .tower_x  (tower_one_x_reg),
        .tower_y  (tower_one_y_reg),
        .rod      (rod_length_squared_reg),
        .target_x (target_x),
        .target_y (target_y),
        .radicand (rad_one),
        .bad      (bad_one)
    );

    dik_radicand u_rad_two (
        .clk      (clk),
        .load     (ctrl.load[FS-1:0]),
        .tower_x  (tower_two_x_reg),
        .tower_y  (tower_two_y_reg),
        .rod      (rod_length_squared_reg),
        .target_x (target_x),
        .target_y (target_y),
        .radicand (rad_two),
        .bad      (bad_two)
    );

    dik_radicand u_rad_three (
        .clk      (clk),
        .load     (ctrl.load[FS-1:0]),
        .tower_x  (tower_three_x_reg),
        .tower_y  (tower_three_y_reg),
        .rod      (rod_length_squared_reg),
        .target_x (target_x),
        .target_y (target_y),
        .radicand (rad_three),
        .bad      (bad_three)
    );

    // square roots per tower
    dik_sqrt u_sqrt_one (
        .clk      (clk),
        .load     (ctrl.load[FS+SS-1:FS]),
        .radicand (rad_one),
        .root     (root_one)
    );

    dik_sqrt u_sqrt_two (
        .clk      (clk),
        .load     (ctrl.load[FS+SS-1:FS]),
        .radicand (rad_two),
        .root     (root_two)
    );

    dik_sqrt u_sqrt_three (
        .clk      (clk),
        .load     (ctrl.load[FS+SS-1:FS]),
        .radicand (rad_three),
        .root     (root_three)
    );

    // target z rides along until the output stage
    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
        begin
            tz_reg[0] <= target_z;
        end
        for (int i = 1; i < PS - 1; i++)
        begin
            if (ctrl.load[i])
            begin
                tz_reg[i] <= tz_reg[i-1];
            end
        end
    end

    // unreachable flag rides along the root stages
    always_ff @(posedge clk)
    begin
        if (ctrl.load[FS])
        begin
            bad_reg[0] <= bad_one | bad_two | bad_three;
        end
        for (int j = 1; j < SS; j++)
        begin
            if (ctrl.load[FS+j])
            begin
                bad_reg[j] <= bad_reg[j-1];
            end
        end
    end

    // output stage: root + z - offset, or zero when unreachable
    assign base    = dik_pkg::OUT_W'(tz_reg[PS-2]) - dik_pkg::OUT_W'(axis_offset_reg);
    assign h_one   = $signed({{(dik_pkg::OUT_W-dik_pkg::ROOT_W){1'b0}}, root_one}) + base;
    assign h_two   = $signed({{(dik_pkg::OUT_W-dik_pkg::ROOT_W){1'b0}}, root_two}) + base;
    assign h_three = $signed({{(dik_pkg::OUT_W-dik_pkg::ROOT_W){1'b0}}, root_three}) + base;

    always_ff @(posedge clk)
    begin
        if (ctrl.load[PS-1])
        begin
            carriage_one_reg   <= bad_reg[SS-1] ? '0 : h_one;
            carriage_two_reg   <= bad_reg[SS-1] ? '0 : h_two;
            carriage_three_reg <= bad_reg[SS-1] ? '0 : h_three;
            unreachable_reg    <= bad_reg[SS-1];
        end
    end

    assign carriage_valid = ctrl.valid[PS-1];
    assign carriage_one   = carriage_one_reg;
    assign carriage_two   = carriage_two_reg;
    assign carriage_three = carriage_three_reg;
    assign unreachable    = unreachable_reg;

    // checks
    `DIK_ASSERT_IMP(a_unreachable_zero, carriage_valid && unreachable, carriage_one == '0 && carriage_two == '0 && carriage_three == '0)
    `DIK_ASSERT_IMP(a_free_output_no_stall, !carriage_stall, !target_stall)
    `DIK_ASSERT_IMP(a_stall_only_when_full, target_stall, ctrl.valid[0] && carriage_valid)
    `DIK_ASSERT_NEXT(a_held_result_stays, carriage_valid && carriage_stall, carriage_valid)

endmodule

`default_nettype wire
